### rtl/core/jdc_pkg.sv
`timescale 1ns / 1ps

package jdc_pkg;

    // Result field widths
    localparam int YEAR_BITS  = 16;
    localparam int MONTH_BITS = 4;
    localparam int DOM_BITS   = 5;

    // Reset value of the switch day (first Gregorian day)
    localparam int GREG_RESET_DAY = 2299161;

    // Reciprocal precision of the constant dividers
    localparam int RECIP_SHIFT = 30;

    // Gregorian cycle in quarter days: 36524.25 * 4, split point 2^17 below it
    localparam int GREG_CYCLE   = 146097;
    localparam int GREG_LO_BITS = 17;
    // 4 * 4479.5 taken off, one whole cycle added to keep the dividend positive
    localparam int GREG_BIAS    = 128179;

    // Julian year in quarter days: 365.25 * 4, split point 2^10 below it
    localparam int JUL_CYCLE    = 1461;
    localparam int JUL_LO_BITS  = 10;

    // Offsets added to 4*J ahead of the year division
    localparam int OFF_JULIAN   = 1461;  // one year, keeps the dividend positive
    localparam int OFF_GREG     = 1309;  // one year less 4 * 38 from the correction
    localparam int CORR_ROUND   = 3;

    // Year numbering
    localparam int YEAR_BIAS    = 4713;

    // Shift of the year start to 1 March: 4 * 59.25 quarter days
    localparam int MARCH_SHIFT  = 237;
    localparam int MARCH_WRAP   = 1224;  // JUL_CYCLE - MARCH_SHIFT

    // Month split in tenths of a day: 30.6 days
    localparam int MONTH_SPAN   = 306;
    localparam int MONTH_COUNT  = 12;
    localparam int TENTH_BIAS   = 5;     // half a day in tenths
    localparam int MONTH_OFFSET = 3;     // March is the first month of the shifted year
    localparam int MONTH_WRAP   = 10;    // shifted months from here fall in the next year
    localparam int MONTH_BACK   = 9;

    // Division of a tenths count by ten: multiply by 205, shift by 11
    localparam int TENTH_RECIP  = 205;
    localparam int TENTH_SHIFT  = 11;

endpackage

### rtl/core/jdc_cdiv.sv
`timescale 1ns / 1ps

// Three-stage floor division of an unsigned value by a constant.
// The divisor must lie strictly between 2^LO_BITS and 2^(LO_BITS+1).
module jdc_cdiv #(
    parameter int X_BITS  = 26,
    parameter int DIVISOR = 1461,
    parameter int LO_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [X_BITS-1:0]             x,
    output logic                          out_valid,
    output logic [X_BITS-LO_BITS-1:0]     quot,
    output logic [$clog2(DIVISOR)-1:0]    rem
);

    localparam int HI_BITS   = X_BITS - LO_BITS;
    localparam int SHIFT     = jdc_pkg::RECIP_SHIFT;
    localparam int PROD_BITS = HI_BITS + SHIFT;
    localparam int REM_BITS  = $clog2(DIVISOR);
    localparam int R2_BITS   = REM_BITS + 1;
    localparam int BACK_BITS = HI_BITS + REM_BITS;
    localparam logic [SHIFT-1:0]     RECIP   = SHIFT'((64'd1 << (SHIFT + LO_BITS)) / DIVISOR);
    localparam logic [R2_BITS-1:0]   DIV_R2  = R2_BITS'(DIVISOR);
    localparam logic [BACK_BITS-1:0] DIV_BK  = BACK_BITS'(DIVISOR);

    logic                 s1_valid_reg;
    logic [X_BITS-1:0]    s1_x_reg;
    logic [PROD_BITS-1:0] s1_prod_reg;
    logic [PROD_BITS-1:0] s1_prod_next;

    logic                 s2_valid_reg;
    logic [X_BITS-1:0]    s2_x_reg;
    logic [HI_BITS-1:0]   s2_qe_reg;
    logic [X_BITS-1:0]    s2_back_reg;
    logic [BACK_BITS-1:0] s2_back_full;

    logic                 out_valid_reg;
    logic [HI_BITS-1:0]   quot_reg;
    logic [REM_BITS-1:0]  rem_reg;
    logic [X_BITS-1:0]    diff;
    logic [R2_BITS-1:0]   part_rem;
    logic                 fix;
    logic [HI_BITS-1:0]   quot_next;
    logic [REM_BITS-1:0]  rem_next;

    // Estimate the quotient from the high bits: short by at most one
    assign s1_prod_next = PROD_BITS'(x[X_BITS-1:LO_BITS]) * PROD_BITS'(RECIP);

    // Multiply the estimate back by the divisor
    assign s2_back_full = BACK_BITS'(s1_prod_reg[PROD_BITS-1:SHIFT]) * DIV_BK;

    // Correct the estimate with one compare and subtract
    always_comb
    begin
        diff      = s2_x_reg - s2_back_reg;
        part_rem  = diff[R2_BITS-1:0];
        fix       = (part_rem >= DIV_R2);
        quot_next = s2_qe_reg + HI_BITS'(fix);
        rem_next  = fix ? REM_BITS'(part_rem - DIV_R2) : part_rem[REM_BITS-1:0];
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Advance the data
    always_ff @(posedge clk)
    begin
        s1_x_reg    <= x;
        s1_prod_reg <= s1_prod_next;
        s2_x_reg    <= s1_x_reg;
        s2_qe_reg   <= s1_prod_reg[PROD_BITS-1:SHIFT];
        s2_back_reg <= s2_back_full[X_BITS-1:0];
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
    end

    assign out_valid = out_valid_reg;
    assign quot      = quot_reg;
    assign rem       = rem_reg;

endmodule

### rtl/core/julian_day_to_calendar_date.sv
`timescale 1ns / 1ps

// Converts a Julian Day Number to year, month and day of month. A request is taken on
// every cycle in which start is high; busy never rises, so a new day number may follow
// in the very next cycle. Each result appears on year, month and day_of_month for one
// cycle under result_valid, in request order, and cannot be held off. The pipeline holds
// two three-stage constant dividers (by 146097 for the Gregorian correction, by 1461
// for the year), each a reciprocal multiply, a back multiply and a single correction
// step, plus six stages of adds and compares around them. Day numbers at or above
// gregorian_start_day get the Gregorian correction; write that register through
// cfg_valid/cfg_ready only while no request is in flight.
module julian_day_to_calendar_date #(
    parameter int DAY_NUMBER_BITS = 23
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [DAY_NUMBER_BITS-1:0]        day_number,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [DAY_NUMBER_BITS-1:0]        gregorian_start_day,
    output logic                              result_valid,
    output logic signed [jdc_pkg::YEAR_BITS-1:0] year,
    output logic [jdc_pkg::MONTH_BITS-1:0]    month,
    output logic [jdc_pkg::DOM_BITS-1:0]      day_of_month
);

    localparam int N        = DAY_NUMBER_BITS;
    localparam int X_BITS   = N + 3;
    localparam int Q1_BITS  = X_BITS - jdc_pkg::GREG_LO_BITS;
    localparam int Q2_BITS  = X_BITS - jdc_pkg::JUL_LO_BITS;
    localparam int C_BITS   = Q1_BITS + 2;
    localparam int OFF_BITS = N - 10;
    localparam int YW       = N - 5;
    localparam int R2_BITS  = $clog2(jdc_pkg::JUL_CYCLE);
    localparam int D0_BITS  = R2_BITS - 2;
    localparam int T_BITS   = D0_BITS + 3;
    localparam int MI_BITS  = jdc_pkg::MONTH_BITS;
    localparam int REM_BITS = $clog2(jdc_pkg::MONTH_SPAN);
    localparam int TEN_BITS = REM_BITS + 8;
    localparam int LATENCY  = 12;
    localparam int DLY      = 3;
    localparam int YB       = jdc_pkg::YEAR_BITS;
    localparam int MB       = jdc_pkg::MONTH_BITS;
    localparam int DB       = jdc_pkg::DOM_BITS;

    logic                 accept;
    logic [N-1:0]         greg_day_reg;

    // Input stage
    logic                 a_valid_reg;
    logic [N-1:0]         a_j_reg;
    logic                 a_ge_reg;
    logic [X_BITS-1:0]    a_x1_reg;
    logic [X_BITS-1:0]    x1_next;

    // Day number and switch flag alongside the first divider
    logic [N-1:0]         j_dly_reg [DLY];
    logic                 ge_dly_reg [DLY];

    logic                 d1_valid;
    logic [Q1_BITS-1:0]   q1;

    // Correction stages
    logic [C_BITS-1:0]    c_sum;
    logic [Q1_BITS-1:0]   c_val;
    logic [OFF_BITS-1:0]  off_next;
    logic                 e_valid_reg;
    logic [N-1:0]         e_j_reg;
    logic [OFF_BITS-1:0]  e_off_reg;
    logic                 f_valid_reg;
    logic [X_BITS-1:0]    f_x2_reg;

    logic                 d2_valid;
    logic [Q2_BITS-1:0]   q2;
    logic [R2_BITS-1:0]   r2;

    // Year and day-in-year stage
    logic signed [YW-1:0] y_base;
    logic signed [YW-1:0] y_adj;
    logic [R2_BITS-1:0]   march;
    logic [D0_BITS-1:0]   d0;
    logic [T_BITS-1:0]    t_next;
    logic                 g_valid_reg;
    logic [YB-1:0]        g_year_reg;
    logic [T_BITS-1:0]    g_t_reg;

    // Month stage
    logic [MI_BITS-1:0]   mi;
    logic [T_BITS-1:0]    span;
    logic [REM_BITS-1:0]  rem_next;
    logic [MB-1:0]        month_next;
    logic                 h_valid_reg;
    logic [YB-1:0]        h_year_reg;
    logic [MB-1:0]        h_month_reg;
    logic [REM_BITS-1:0]  h_rem_reg;

    // Output stage
    logic [TEN_BITS-1:0]  tenths;
    logic [DB-1:0]        dom_next;
    logic                 out_valid_reg;
    logic [YB-1:0]        year_reg;
    logic [MB-1:0]        month_reg;
    logic [DB-1:0]        dom_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Hold the switch day
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            greg_day_reg <= N'(jdc_pkg::GREG_RESET_DAY);
        end
        else if (cfg_valid && cfg_ready)
        begin
            greg_day_reg <= gregorian_start_day;
        end
    end

    // Take the request: compare with the switch day, bias the quarter-day count
    assign x1_next = {1'b0, day_number, 2'b00} + X_BITS'(jdc_pkg::GREG_BIAS);

    always_ff @(posedge clk)
    begin
        a_j_reg  <= day_number;
        a_ge_reg <= (day_number >= greg_day_reg);
        a_x1_reg <= x1_next;
    end

    // Count of Gregorian cycles, plus one
    jdc_cdiv #(
        .X_BITS  (X_BITS),
        .DIVISOR (jdc_pkg::GREG_CYCLE),
        .LO_BITS (jdc_pkg::GREG_LO_BITS)
    ) u_greg_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .x         (a_x1_reg),
        .out_valid (d1_valid),
        .quot      (q1),
        .rem       ()
    );

    // Delay the day number and switch flag to meet the quotient
    always_ff @(posedge clk)
    begin
        j_dly_reg[0]  <= a_j_reg;
        ge_dly_reg[0] <= a_ge_reg;
        for (int i = 1; i < DLY; i++)
        begin
            j_dly_reg[i]  <= j_dly_reg[i-1];
            ge_dly_reg[i] <= ge_dly_reg[i-1];
        end
    end

    // Build the offset: 4 * correction + one year, or one year alone
    always_comb
    begin
        c_sum    = ({2'b00, q1} << 1) + {2'b00, q1} + C_BITS'(jdc_pkg::CORR_ROUND);
        c_val    = c_sum[C_BITS-1:2];
        off_next = ge_dly_reg[DLY-1]
                 ? OFF_BITS'({c_val, 2'b00}) + OFF_BITS'(jdc_pkg::OFF_GREG)
                 : OFF_BITS'(jdc_pkg::OFF_JULIAN);
    end

    always_ff @(posedge clk)
    begin
        e_j_reg   <= j_dly_reg[DLY-1];
        e_off_reg <= off_next;
        f_x2_reg  <= {1'b0, e_j_reg, 2'b00} + X_BITS'(e_off_reg);
    end

    // Years since the epoch, plus one, and quarter days into the year
    jdc_cdiv #(
        .X_BITS  (X_BITS),
        .DIVISOR (jdc_pkg::JUL_CYCLE),
        .LO_BITS (jdc_pkg::JUL_LO_BITS)
    ) u_year_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid_reg),
        .x         (f_x2_reg),
        .out_valid (d2_valid),
        .quot      (q2),
        .rem       (r2)
    );

    // Drop year zero; rotate the year start to 1 March
    always_comb
    begin
        y_base = $signed(YW'(q2)) - $signed(YW'(jdc_pkg::YEAR_BIAS));
        y_adj  = (y_base[YW-1] || (y_base == '0)) ? y_base - YW'(1) : y_base;
        march  = (r2 >= R2_BITS'(jdc_pkg::MARCH_SHIFT))
               ? r2 - R2_BITS'(jdc_pkg::MARCH_SHIFT)
               : r2 + R2_BITS'(jdc_pkg::MARCH_WRAP);
        d0     = march[R2_BITS-1:2];
        t_next = T_BITS'({d0, 3'b000}) + T_BITS'({d0, 1'b0})
               + T_BITS'(jdc_pkg::TENTH_BIAS);
    end

    always_ff @(posedge clk)
    begin
        g_year_reg <= y_adj[YB-1:0];
        g_t_reg    <= t_next;
    end

    // Split tenths of a day into months of 30.6 days
    always_comb
    begin
        mi = '0;
        for (int k = 1; k < jdc_pkg::MONTH_COUNT; k++)
        begin
            if (g_t_reg >= T_BITS'(k * jdc_pkg::MONTH_SPAN))
            begin
                mi = mi + MI_BITS'(1);
            end
        end
        span       = T_BITS'(mi) * T_BITS'(jdc_pkg::MONTH_SPAN);
        rem_next   = REM_BITS'(g_t_reg - span);
        month_next = (mi < MI_BITS'(jdc_pkg::MONTH_WRAP))
                   ? MB'(mi + MI_BITS'(jdc_pkg::MONTH_OFFSET))
                   : MB'(mi - MI_BITS'(jdc_pkg::MONTH_BACK));
    end

    always_ff @(posedge clk)
    begin
        h_year_reg  <= g_year_reg;
        h_month_reg <= month_next;
        h_rem_reg   <= rem_next;
    end

    // Whole days from the tenths left over
    always_comb
    begin
        tenths   = TEN_BITS'(h_rem_reg) * TEN_BITS'(jdc_pkg::TENTH_RECIP);
        dom_next = DB'(tenths >> jdc_pkg::TENTH_SHIFT) + DB'(1);
    end

    always_ff @(posedge clk)
    begin
        year_reg  <= h_year_reg;
        month_reg <= h_month_reg;
        dom_reg   <= dom_next;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= accept;
            e_valid_reg   <= d1_valid;
            f_valid_reg   <= e_valid_reg;
            g_valid_reg   <= d2_valid;
            h_valid_reg   <= g_valid_reg;
            out_valid_reg <= h_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign year         = $signed(year_reg);
    assign month        = month_reg;
    assign day_of_month = dom_reg;

    // Every request yields its result after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY result_valid)
        else $error("request lost in the pipeline");

    // No result appears without a request at the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, LATENCY))
        else $error("result without a matching request");

    // Month of a result stays in 1 to 12 and its day of month is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (month != '0 && month <= MB'(jdc_pkg::MONTH_COUNT)
                          && day_of_month != '0))
        else $error("month or day out of range");

endmodule

### tb/julian_day_to_calendar_date_checker.sv
`timescale 1ns / 1ps

// Watches the request, configuration and result channels of the day number converter,
// works out the calendar date of every accepted request and compares it, in order,
// with the date that comes back.
module julian_day_to_calendar_date_checker #(
    parameter int DAY_BITS = 23
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic [DAY_BITS-1:0]                   day_number,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [DAY_BITS-1:0]                   gregorian_start_day,
    input  logic                                  result_valid,
    input  logic signed [jdc_pkg::YEAR_BITS-1:0]  year,
    input  logic [jdc_pkg::MONTH_BITS-1:0]        month,
    input  logic [jdc_pkg::DOM_BITS-1:0]          day_of_month,
    output int                                    outstanding,
    output int                                    fail_count
);

    // Day quantities in hundredths of a day
    localparam longint CENTURY_EPOCH   = 447950;    // 4479.5 days
    localparam longint GREG_CENTURY    = 3652425;   // 36524.25 days
    localparam longint JULIAN_YEAR     = 36525;     // 365.25 days
    localparam longint MARCH_START     = 5925;      // 59.25 days
    localparam longint MONTH_LENGTH    = 3060;      // 30.6 days
    localparam longint YEAR_ORIGIN     = 4712;
    localparam longint CORR_OFFSET     = 37;
    localparam int     REPORT_LIMIT    = 10;

    typedef struct packed {
        logic signed [jdc_pkg::YEAR_BITS-1:0] year;
        logic [jdc_pkg::MONTH_BITS-1:0]       month;
        logic [jdc_pkg::DOM_BITS-1:0]         dom;
    } civil_date_t;

    civil_date_t          pending_dates[$];
    civil_date_t          want;
    logic [DAY_BITS-1:0]  switch_day_q;
    int                   reported;

    // Floor division by a positive constant
    function automatic longint floor_div(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // Calendar date of one day number under the given switch day
    function automatic civil_date_t calendar_of_day(input logic [DAY_BITS-1:0] jd,
                                                    input logic [DAY_BITS-1:0] switch_day);
        longint      j;
        longint      centuries;
        longint      shifted;
        longint      yr;
        longint      doy;
        longint      tenths;
        longint      mon;
        longint      dd;
        civil_date_t r;
        j = longint'(jd);
        // add the Gregorian correction from the switch day onward
        if (jd >= switch_day)
        begin
            centuries = floor_div(100 * j - CENTURY_EPOCH, GREG_CENTURY);
            j = j + floor_div(3 * centuries + 2, 4) - CORR_OFFSET;
        end
        yr = floor_div(100 * j, JULIAN_YEAR) - YEAR_ORIGIN;
        shifted = 100 * j - MARCH_START;
        doy = (shifted - floor_div(shifted, JULIAN_YEAR) * JULIAN_YEAR) / 100;
        tenths = 100 * doy + 50;
        mon = ((tenths / MONTH_LENGTH) + 2) % 12 + 1;
        dd = (tenths % MONTH_LENGTH) / 100 + 1;
        // no year zero
        if (yr <= 0)
            yr = yr - 1;
        r.year = yr[jdc_pkg::YEAR_BITS-1:0];
        r.month = mon[jdc_pkg::MONTH_BITS-1:0];
        r.dom = dd[jdc_pkg::DOM_BITS-1:0];
        return r;
    endfunction

    // Count a failure, report only the first few
    task automatic flag_error(input string what, input civil_date_t exp_date);
        fail_count = fail_count + 1;
        if (reported < REPORT_LIMIT)
        begin
            reported = reported + 1;
            $display("[%0t] %s: expected %0d-%0d-%0d, got %0d-%0d-%0d", $realtime, what,
                     exp_date.year, exp_date.month, exp_date.dom, year, month, day_of_month);
        end
    endtask

    initial
    begin
        fail_count = 0;
        reported = 0;
    end

    // Check results, predict new requests, track the switch day
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_dates.delete();
            switch_day_q <= DAY_BITS'(jdc_pkg::GREG_RESET_DAY);
            outstanding <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (pending_dates.size() == 0)
                    flag_error("result with no request waiting", '0);
                else
                begin
                    want = pending_dates.pop_front();
                    if (year !== want.year || month !== want.month
                        || day_of_month !== want.dom)
                        flag_error("date mismatch", want);
                end
            end
            if (start && !busy)
                pending_dates.push_back(calendar_of_day(day_number, switch_day_q));
            if (cfg_valid && cfg_ready)
                switch_day_q <= gregorian_start_day;
            outstanding <= pending_dates.size();
        end
    end

endmodule

### tb/julian_day_to_calendar_date_tb.sv
`timescale 1ns / 1ps

module julian_day_to_calendar_date_tb;

    localparam int                  DAY_BITS         = 23;
    localparam logic [DAY_BITS-1:0] DAY_MAX          = '1;
    localparam int                  RANDOM_PER_PHASE = 205;
    localparam int                  PHASES           = 8;
    localparam int                  IDLE_LIMIT       = 2000;
    localparam int                  SETTLE_CYCLES    = 16;
    localparam int                  EPOCH_AD         = 1721424;  // 1 January of year 1
    localparam int                  MODERN_LIMIT     = 5373484;  // 31 December 9999

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic [DAY_BITS-1:0]                  day_number;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [DAY_BITS-1:0]                  gregorian_start_day;
    logic                                 result_valid;
    logic signed [jdc_pkg::YEAR_BITS-1:0] year;
    logic [jdc_pkg::MONTH_BITS-1:0]       month;
    logic [jdc_pkg::DOM_BITS-1:0]         day_of_month;
    int                                   outstanding;
    int                                   fail_count;
    int                                   stall_cycles;
    int                                   burst_left;
    logic [DAY_BITS-1:0]                  switch_day;

    // Calendar landmarks: range ends, the switch, no year zero, leap days, year ends
    int landmark_days [0:19] = '{
        0, 1, 8388607, 8388606, 2299159, 2299160, 2299161, 2299162,
        1721423, 1721424, 1720692, 2451544, 2451545, 2451604, 2451605,
        2415079, 2415080, 2460676, 5373484, 3000000
    };

    julian_day_to_calendar_date #(
        .DAY_NUMBER_BITS (DAY_BITS)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .day_number          (day_number),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .gregorian_start_day (gregorian_start_day),
        .result_valid        (result_valid),
        .year                (year),
        .month               (month),
        .day_of_month        (day_of_month)
    );

    julian_day_to_calendar_date_checker #(
        .DAY_BITS (DAY_BITS)
    ) u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .day_number          (day_number),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .gregorian_start_day (gregorian_start_day),
        .result_valid        (result_valid),
        .year                (year),
        .month               (month),
        .day_of_month        (day_of_month),
        .outstanding         (outstanding),
        .fail_count          (fail_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("julian_day_to_calendar_date_tb failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Issue one request, then hold off for a random gap unless in a burst
    task automatic send_day(input logic [DAY_BITS-1:0] d);
        int gap;
        int roll;
        start <= 1'b1;
        day_number <= d;
        do @(posedge clk); while (busy);
        gap = 0;
        if (burst_left > 0)
            burst_left = burst_left - 1;
        else if ($urandom_range(0, 7) == 0)
            burst_left = $urandom_range(20, 60);
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 98)
                gap = $urandom_range(20, 40);
            else if (roll >= 90)
                gap = $urandom_range(4, 10);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and hold until every request has its result
    task automatic wait_drained;
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_switch_day(input logic [DAY_BITS-1:0] v);
        cfg_valid <= 1'b1;
        gregorian_start_day <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        switch_day = v;
    endtask

    // Random day numbers: full range, historic dates, near the switch, near year one and near the range ends
    task automatic run_random(input int count);
        int                  i;
        int                  roll;
        int                  near;
        logic [DAY_BITS-1:0] d;
        for (i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 9);
            if (roll <= 2)
                d = DAY_BITS'($urandom);
            else if (roll <= 5)
                d = DAY_BITS'($urandom_range(0, MODERN_LIMIT));
            else if (roll <= 8)
            begin
                if (roll <= 7)
                    near = int'(switch_day) + int'($urandom_range(0, 4000)) - 2000;
                else
                    near = EPOCH_AD + int'($urandom_range(0, 1600)) - 800;
                if (near < 0)
                    near = 0;
                if (near > int'(DAY_MAX))
                    near = int'(DAY_MAX);
                d = DAY_BITS'(near);
            end
            else if ($urandom_range(0, 1) == 0)
                d = DAY_BITS'($urandom_range(0, 100));
            else
                d = DAY_MAX - DAY_BITS'($urandom_range(0, 100));
            send_day(d);
            if (i == count / 2 || $urandom_range(0, 149) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        int p;
        logic [DAY_BITS-1:0] next_switch;
        rst_n <= 1'b0;
        start <= 1'b0;
        day_number <= '0;
        cfg_valid <= 1'b0;
        gregorian_start_day <= '0;
        stall_cycles <= 0;
        burst_left = 0;
        switch_day = DAY_BITS'(jdc_pkg::GREG_RESET_DAY);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // landmarks under the reset switch day
        foreach (landmark_days[k])
            send_day(DAY_BITS'(landmark_days[k]));
        wait_drained();

        // switch day at zero: early days correct to below the epoch
        write_switch_day('0);
        send_day('0);
        send_day(DAY_BITS'(1));
        send_day(DAY_BITS'(37));
        send_day(DAY_MAX);
        run_random(RANDOM_PER_PHASE);

        // advance through further switch days, extremes first
        for (p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:       next_switch = DAY_MAX;
                1:       next_switch = DAY_BITS'(jdc_pkg::GREG_RESET_DAY);
                2:       next_switch = DAY_BITS'(1);
                3:       next_switch = DAY_MAX - 1'b1;
                4:       next_switch = DAY_BITS'($urandom_range(0, MODERN_LIMIT));
                default: next_switch = DAY_BITS'($urandom);
            endcase
            write_switch_day(next_switch);
            run_random(RANDOM_PER_PHASE);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("julian_day_to_calendar_date_tb passed");
        else
            $display("julian_day_to_calendar_date_tb failed");
        $finish;
    end

endmodule
